// ----- rtl/pfd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types, register codes and saturation helper for the ping-pong delay.
// ----------------------------------------------------------------------------
package pfd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;
    localparam int SAT_W       = 37;   // widest pre-saturation sum

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY_LEFT  = 3'd0,
        CFG_DELAY_RIGHT = 3'd1,
        CFG_FEEDBACK    = 3'd2,
        CFG_PINGPONG    = 3'd3,
        CFG_WET_GAIN    = 3'd4,
        CFG_DRY_GAIN    = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FEED,
        ST_MIX_MUL,
        ST_MIX_SUM,
        ST_WET_MUL,
        ST_WET_SUM
    } pfd_state_t;

    localparam logic [16:0] Q16_ONE      = 17'h10000;
    localparam logic [16:0] DELAY_RST    = 17'd14400;
    localparam logic [16:0] FEEDBACK_RST = 17'd32768;
    localparam logic [16:0] PINGPONG_RST = 17'd0;
    localparam logic [15:0] WET_RST      = 16'd2053;
    localparam logic [15:0] DRY_RST      = 16'd4096;

    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(2**(SAMPLE_BITS-1) - 1);
    localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [SAT_W-1:0] x
    );
        if (x > SAT_HI) begin
            return SAT_HI[SAMPLE_BITS-1:0];
        end else if (x < SAT_LO) begin
            return SAT_LO[SAMPLE_BITS-1:0];
        end
        return x[SAMPLE_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/pingpong_feedback_delay.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pingpong_feedback_delay
// Stereo ping-pong feedback delay, one stereo word in, one stereo word out.
// ----------------------------------------------------------------------------
// After acceptance each input word passes the states FEED, MIX_MUL, MIX_SUM,
// WET_MUL and WET_SUM before the result is loaded into the output register;
// a new word can be accepted the cycle after the previous one has reached it,
// so one word at most is in flight. A result still waiting in the output
// register holds the last stage, and the input stays closed until taken.
// The state sequence is set by the single read port of each line memory (old
// sample, then oldest sample after the write) and by one register stage after
// every multiply group. The line memories are not swept on reset: a
// per-channel fill count (high-water mark of written entries) makes every
// never-written entry read as zero, so words are accepted right after reset.
// Config may only be written while the block is idle.
// ----------------------------------------------------------------------------
module pingpong_feedback_delay
    import pfd_pkg::*;
#(
    parameter int MAX_DELAY = 65536
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [31:0]           s_tdata,    // [15:0] left_in, [31:16] right_in
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [31:0]           m_tdata,    // [15:0] left_out, [31:16] right_out
    // config write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int ADDR_W = $clog2(MAX_DELAY);
    localparam int LEN_W  = $clog2(MAX_DELAY + 1);
    localparam int CMP_W  = (LEN_W > 17) ? LEN_W : 17;
    localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_DELAY);

    localparam int FEED_W = 18;             // input + scaled feedback
    localparam int FBP_W  = 34;             // 16s x 18s
    localparam int MIXP_W = 36;             // 18s x 18s
    localparam int MIX_W  = 37;
    localparam int OUTP_W = 33;             // 16s x 17s
    localparam int OUT_W  = 34;

    localparam logic signed [FBP_W-1:0] FB_HALF  = FBP_W'(32768);
    localparam logic signed [MIX_W-1:0] MIX_HALF = MIX_W'(32768);
    localparam logic signed [OUT_W-1:0] OUT_HALF = OUT_W'(2048);

    // ---------------- config registers ----------------
    logic [16:0] delay_reg [2];     // 0 left, 1 right
    logic [16:0] feedback_reg;
    logic [16:0] pingpong_reg;
    logic [15:0] wet_reg;
    logic [15:0] dry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg[0] <= DELAY_RST;
            delay_reg[1] <= DELAY_RST;
            feedback_reg <= FEEDBACK_RST;
            pingpong_reg <= PINGPONG_RST;
            wet_reg      <= WET_RST;
            dry_reg      <= DRY_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_DELAY_LEFT:  delay_reg[0] <= cfg_wdata;
                CFG_DELAY_RIGHT: delay_reg[1] <= cfg_wdata;
                CFG_FEEDBACK:    feedback_reg <= cfg_wdata;
                CFG_PINGPONG:    pingpong_reg <= cfg_wdata;
                CFG_WET_GAIN:    wet_reg      <= cfg_wdata[15:0];
                CFG_DRY_GAIN:    dry_reg      <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // feedback and ping-pong clamped at unity; keep is the share that stays on its own side
    logic [16:0]        fb_clamp, pp_clamp, keep;
    logic signed [17:0] fb_s, pp_s, keep_s;
    logic signed [16:0] wet_s, dry_s;

    always_comb begin
        fb_clamp = (feedback_reg > Q16_ONE) ? Q16_ONE : feedback_reg;
        pp_clamp = (pingpong_reg > Q16_ONE) ? Q16_ONE : pingpong_reg;
        keep     = Q16_ONE - pp_clamp;
        fb_s     = $signed({1'b0, fb_clamp});
        pp_s     = $signed({1'b0, pp_clamp});
        keep_s   = $signed({1'b0, keep});
        wet_s    = $signed({1'b0, wet_reg});
        dry_s    = $signed({1'b0, dry_reg});
    end

    // ---------------- control ----------------
    pfd_state_t state_reg, state_next;
    logic       rd_en, wr_en, out_load, accept;

    assign accept = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (s_tvalid) state_next = ST_FEED;
            ST_FEED:    state_next = ST_MIX_MUL;
            ST_MIX_MUL: state_next = ST_MIX_SUM;
            ST_MIX_SUM: state_next = ST_WET_MUL;
            ST_WET_MUL: state_next = ST_WET_SUM;
            ST_WET_SUM: if (!m_tvalid || m_tready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                rd_en    = s_tvalid;       // read line at current position
            end
            ST_FEED:    rd_en = 1'b1;      // read oldest entry after the write
            ST_MIX_SUM: wr_en = 1'b1;
            ST_WET_SUM: out_load = !m_tvalid || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- per-channel state and datapath ----------------
    logic [ADDR_W-1:0]          pos_reg   [2];   // holds p from accept until the write
    logic [ADDR_W-1:0]          pn_reg    [2];
    logic [LEN_W-1:0]           fill_reg  [2];   // entries [0, fill) written
    logic                       old_ok_reg[2];
    logic                       new_ok_reg[2];
    logic                       same_reg  [2];
    logic signed [SAMPLE_BITS-1:0] x_reg  [2];
    logic signed [FEED_W-1:0]   feed_reg  [2];
    logic signed [MIXP_W-1:0]   mk_reg    [2];   // own feed x keep
    logic signed [MIXP_W-1:0]   mx_reg    [2];   // other feed x pingpong
    logic signed [SAMPLE_BITS-1:0] v_reg  [2];
    logic signed [OUTP_W-1:0]   wp_reg    [2];
    logic signed [OUTP_W-1:0]   dp_reg    [2];
    logic signed [SAMPLE_BITS-1:0] o_reg  [2];
    logic                       m_tvalid_reg;

    logic [SAMPLE_BITS-1:0]     rdata     [2];
    logic [ADDR_W-1:0]          rd_addr   [2];

    logic [CMP_W-1:0]           dly_wide  [2];
    logic [LEN_W-1:0]           len       [2];
    logic [LEN_W-1:0]           inc       [2];
    logic [LEN_W-1:0]           fill_new  [2];
    logic [ADDR_W-1:0]          p_fix     [2];
    logic [ADDR_W-1:0]          pn_fix    [2];
    logic signed [SAMPLE_BITS-1:0] line_old [2];
    logic signed [FBP_W-1:0]    fbp       [2];
    logic signed [FBP_W-1:0]    fbr       [2];
    logic signed [FEED_W-1:0]   feed_next [2];
    logic signed [MIX_W-1:0]    mix_sum   [2];
    logic signed [SAMPLE_BITS-1:0] v_next [2];
    logic signed [SAMPLE_BITS-1:0] wet_src [2];
    logic signed [OUT_W-1:0]    out_sum   [2];
    logic signed [SAMPLE_BITS-1:0] o_next [2];

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            // zero length acts as one, too long acts as MAX_DELAY
            dly_wide[c] = CMP_W'(delay_reg[c]);
            if (dly_wide[c] == '0) begin
                len[c] = LEN_W'(1);
            end else if (dly_wide[c] > MAX_LEN) begin
                len[c] = LEN_W'(MAX_DELAY);
            end else begin
                len[c] = LEN_W'(dly_wide[c]);
            end

            // position restarts if the line was shortened under it
            p_fix[c]    = (LEN_W'(pos_reg[c]) >= len[c]) ? '0 : pos_reg[c];
            inc[c]      = LEN_W'(pos_reg[c]) + LEN_W'(1);
            pn_fix[c]   = (inc[c] >= len[c]) ? '0 : inc[c][ADDR_W-1:0];
            fill_new[c] = (inc[c] > fill_reg[c]) ? inc[c] : fill_reg[c];

            line_old[c]  = old_ok_reg[c] ? $signed(rdata[c]) : '0;
            fbp[c]       = line_old[c] * fb_s;
            fbr[c]       = fbp[c] + FB_HALF;
            feed_next[c] = FEED_W'(x_reg[c]) + FEED_W'($signed(fbr[c][FBP_W-1:16]));

            mix_sum[c] = MIX_W'(mk_reg[c]) + MIX_W'(mx_reg[c]) + MIX_HALF;
            v_next[c]  = sat_sample(SAT_W'($signed(mix_sum[c][MIX_W-1:16])));

            // length one: oldest entry is the one just written
            if (same_reg[c]) begin
                wet_src[c] = v_reg[c];
            end else begin
                wet_src[c] = new_ok_reg[c] ? $signed(rdata[c]) : '0;
            end
            out_sum[c] = OUT_W'(wp_reg[c]) + OUT_W'(dp_reg[c]) + OUT_HALF;
            o_next[c]  = sat_sample(SAT_W'($signed(out_sum[c][OUT_W-1:12])));
        end
    end

    // read address: current position at accept, next position afterwards
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            rd_addr[c] = (state_reg == ST_IDLE) ? p_fix[c] : pn_fix[c];
        end
    end

    // control part of channel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < 2; c++) begin
                pos_reg[c]  <= '0;
                fill_reg[c] <= '0;
            end
        end else begin
            for (int c = 0; c < 2; c++) begin
                if (accept) begin
                    pos_reg[c] <= p_fix[c];
                end else if (wr_en) begin
                    pos_reg[c] <= pn_reg[c];
                end
                if (state_reg == ST_FEED) begin
                    fill_reg[c] <= fill_new[c];
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        for (int c = 0; c < 2; c++) begin
            if (accept) begin
                x_reg[c]      <= $signed(s_tdata[c*SAMPLE_BITS +: SAMPLE_BITS]);
                old_ok_reg[c] <= LEN_W'(p_fix[c]) < fill_reg[c];
            end
            if (state_reg == ST_FEED) begin
                feed_reg[c]   <= feed_next[c];
                pn_reg[c]     <= pn_fix[c];
                new_ok_reg[c] <= LEN_W'(pn_fix[c]) < fill_new[c];
                same_reg[c]   <= pn_fix[c] == pos_reg[c];
            end
            if (state_reg == ST_MIX_MUL) begin
                mk_reg[c] <= feed_reg[c] * keep_s;
                mx_reg[c] <= feed_reg[1-c] * pp_s;
            end
            if (wr_en) begin
                v_reg[c] <= v_next[c];
            end
            if (state_reg == ST_WET_MUL) begin
                wp_reg[c] <= wet_src[c] * wet_s;
                dp_reg[c] <= x_reg[c] * dry_s;
            end
            if (out_load) begin
                o_reg[c] <= o_next[c];
            end
        end
    end

    // output register, freed by the sink independent of the datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {o_reg[1], o_reg[0]};

    // ---------------- delay line memories ----------------
    for (genvar g = 0; g < 2; g++) begin : g_line
        pfd_line_ram #(
            .DEPTH (MAX_DELAY),
            .WIDTH (SAMPLE_BITS)
        ) u_ram (
            .aclk    (aclk),
            .wr_en   (wr_en),
            .wr_addr (pos_reg[g]),
            .wr_data (v_next[g]),
            .rd_en   (rd_en),
            .rd_addr (rd_addr[g]),
            .rd_data (rdata[g])
        );
    end

endmodule
`default_nettype wire

// ----- rtl/pfd_line_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_line_ram
// Simple dual-port delay line memory, one write and one registered read.
// ----------------------------------------------------------------------------
module pfd_line_ram #(
    parameter int DEPTH = 65536,
    parameter int WIDTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/pfd_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_checker
// Port-level checks for the ping-pong delay, bound to the top level.
// ----------------------------------------------------------------------------
module pfd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one word in flight: busy right after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a word is in flight");

    // no result can appear the cycle after an accept
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early");

    // a new result is only loaded while the input side is busy
    a_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result loaded while idle");

endmodule

bind pingpong_feedback_delay pfd_checker u_pfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ----- sim/pingpong_feedback_delay_checker.sv -----
// ----------------------------------------------------------------------------
// pingpong_feedback_delay_checker
// Watches the stream and config ports of the ping-pong delay, models its
// two feedback lines and compares every output word with the prediction.
// ----------------------------------------------------------------------------
module pingpong_feedback_delay_checker
    import pfd_pkg::*;
#(
    parameter int MAX_DELAY = 65536
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [31:0]           s_tdata,    // [15:0] left_in, [31:16] right_in
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [31:0]           m_tdata,    // [15:0] left_out, [31:16] right_out
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                         pending_words,
    output int                         fail_count
);

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } stereo_t;

    // shadow copy of the registers
    logic [16:0] len_l_reg, len_r_reg, fb_reg, pp_reg;
    logic [15:0] wet_reg, dry_reg;

    logic signed [15:0] echo_l [0:MAX_DELAY-1];
    logic signed [15:0] echo_r [0:MAX_DELAY-1];
    int unsigned        pos_l, pos_r;

    stereo_t expected_out_q [$];

    initial begin
        pending_words = 0;
        fail_count    = 0;
    end

    function automatic longint round_down_shift(longint x, int s);
        // nearest, ties toward plus infinity
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [15:0] clip16(longint x);
        if (x > 32767) return 16'sh7fff;
        if (x < -32768) return 16'sh8000;
        return 16'(x);
    endfunction

    function automatic int unsigned usable_len(logic [16:0] r);
        if (r == 0) return 1;
        if (r > MAX_DELAY) return MAX_DELAY;
        return r;
    endfunction

    function automatic longint unity_clamp(logic [16:0] g);
        return (g > Q16_ONE) ? longint'(Q16_ONE) : longint'(g);
    endfunction

    function automatic void clear_echo_lines();
        for (int i = 0; i < MAX_DELAY; i++) begin
            echo_l[i] = '0;
            echo_r[i] = '0;
        end
        pos_l = 0;
        pos_r = 0;
    endfunction

    function automatic stereo_t echo_frame(logic signed [15:0] in_l, logic signed [15:0] in_r);
        int unsigned len_l, len_r;
        longint      fb, pp, keep, x_l, x_r, feed_l, feed_r;
        stereo_t     res;
        len_l = usable_len(len_l_reg);
        len_r = usable_len(len_r_reg);
        fb    = unity_clamp(fb_reg);
        pp    = unity_clamp(pp_reg);
        keep  = longint'(Q16_ONE) - pp;
        x_l   = longint'(in_l);
        x_r   = longint'(in_r);
        // a shrunk line restarts at the top
        if (pos_l >= len_l) pos_l = 0;
        if (pos_r >= len_r) pos_r = 0;
        feed_l = x_l + round_down_shift(longint'(echo_l[pos_l]) * fb, 16);
        feed_r = x_r + round_down_shift(longint'(echo_r[pos_r]) * fb, 16);
        echo_l[pos_l] = clip16(round_down_shift(feed_l * keep + feed_r * pp, 16));
        echo_r[pos_r] = clip16(round_down_shift(feed_r * keep + feed_l * pp, 16));
        pos_l = (pos_l + 1 >= len_l) ? 0 : pos_l + 1;
        pos_r = (pos_r + 1 >= len_r) ? 0 : pos_r + 1;
        res.left  = clip16(round_down_shift(longint'(echo_l[pos_l]) * longint'(wet_reg)
                                            + x_l * longint'(dry_reg), 12));
        res.right = clip16(round_down_shift(longint'(echo_r[pos_r]) * longint'(wet_reg)
                                            + x_r * longint'(dry_reg), 12));
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        stereo_t want;
        if (!aresetn) begin
            len_l_reg = DELAY_RST;
            len_r_reg = DELAY_RST;
            fb_reg    = FEEDBACK_RST;
            pp_reg    = PINGPONG_RST;
            wet_reg   = WET_RST;
            dry_reg   = DRY_RST;
            clear_echo_lines();
            expected_out_q.delete();
            pending_words <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_DELAY_LEFT:  len_l_reg = cfg_wdata;
                    CFG_DELAY_RIGHT: len_r_reg = cfg_wdata;
                    CFG_FEEDBACK:    fb_reg    = cfg_wdata;
                    CFG_PINGPONG:    pp_reg    = cfg_wdata;
                    CFG_WET_GAIN:    wet_reg   = cfg_wdata[15:0];
                    CFG_DRY_GAIN:    dry_reg   = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_out_q.size() == 0) begin
                    report_mismatch("unexpected word", m_tdata[15:0], '0);
                end else begin
                    want = expected_out_q.pop_front();
                    if (m_tdata[15:0] !== want.left)
                        report_mismatch("left_out", m_tdata[15:0], want.left);
                    if (m_tdata[31:16] !== want.right)
                        report_mismatch("right_out", m_tdata[31:16], want.right);
                end
            end
            if (s_tvalid && s_tready)
                expected_out_q.push_back(echo_frame(s_tdata[15:0], s_tdata[31:16]));
            pending_words <= expected_out_q.size();
        end
    end

endmodule

// ----- sim/pingpong_feedback_delay_test.sv -----
// ----------------------------------------------------------------------------
// pingpong_feedback_delay_test
// Stimulus and verdict for the stereo ping-pong delay: directed corner words,
// then random segments under changing register settings and idling patterns.
// ----------------------------------------------------------------------------
module pingpong_feedback_delay_test;
    import pfd_pkg::*;

    localparam int QUIET_LIMIT  = 3000;  // cycles without any handshake
    localparam int HOLD_CYCLES  = 200;   // long receiver hold-off
    localparam int SETTLE       = 16;    // block latency plus margin
    localparam int SEGMENTS     = 13;
    localparam int SEG_WORDS    = 100;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;   // [15:0] left_in, [31:16] right_in
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;          // [15:0] left_out, [31:16] right_out
    logic                  cfg_we    = 1'b0;
    cfg_idx_t              cfg_addr  = CFG_DELAY_LEFT;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int pending_words;
    int fail_count;

    // idling knobs: sender idle_pct is used only by the stimulus process,
    // stall_pct and hold_flip are handed to the receiver process by NBA
    int   idle_pct   = 0;
    int   stall_pct  = 0;
    logic hold_flip  = 1'b0;
    logic hold_seen  = 1'b0;
    int   hold_left  = 0;
    int   quiet_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    pingpong_feedback_delay u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    pingpong_feedback_delay_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .pending_words (pending_words),
        .fail_count    (fail_count)
    );

    // Receiver: random stalls, or a long hold-off whenever hold_flip toggles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
        end else if (hold_flip != hold_seen) begin
            hold_seen <= hold_flip;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: any word moving on either side resets the count.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offer one stereo word; tvalid stays high on return so back-to-back words
    // keep it asserted. Gaps are only inserted before the word.
    task automatic send_frame(logic [15:0] left, logic [15:0] right);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stop offering and let every predicted word come out, then give the
    // pipe its latency so the block is surely idle.
    task automatic drain_block();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic apply_settings(logic [16:0] dl, logic [16:0] dr, logic [16:0] fb,
                                  logic [16:0] pp, logic [16:0] wet, logic [16:0] dry);
        write_reg(CFG_DELAY_LEFT,  dl);
        write_reg(CFG_DELAY_RIGHT, dr);
        write_reg(CFG_FEEDBACK,    fb);
        write_reg(CFG_PINGPONG,    pp);
        write_reg(CFG_WET_GAIN,    wet);
        write_reg(CFG_DRY_GAIN,    dry);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [16:0] pick_length();
        case ($urandom_range(15))
            0:       return 17'd0;                       // acts as one
            1:       return 17'd1;
            2:       return 17'd65536;
            3:       return 17'($urandom_range(65537, 131071)); // clamps to max
            4:       return 17'($urandom_range(1, 65536));
            default: return 17'($urandom_range(1, 48));  // short lines echo often
        endcase
    endfunction

    function automatic logic [16:0] pick_q16();
        case ($urandom_range(7))
            0:       return 17'd0;
            1:       return 17'd65536;
            2:       return 17'($urandom_range(65537, 131071)); // above unity
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [16:0] pick_gain();
        case ($urandom_range(7))
            0:       return 17'd0;                       // mute
            1:       return 17'd65535;
            2:       return 17'd4096;                    // unity
            3:       return 17'($urandom);               // bit 16 is dropped
            default: return 17'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2, 3:    return 16'($urandom_range(0, 64) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int seg;
        int k;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed words ---
        // reset settings, full-scale words
        send_frame(16'h7fff, 16'h8000);
        send_frame(16'h8000, 16'h7fff);
        send_frame(16'h0000, 16'h0000);
        send_frame(16'hffff, 16'h0001);
        drain_block();

        // zero length, oversize length, feedback and ping-pong above unity,
        // maximum gains to force saturation
        apply_settings(17'd0, 17'd131071, 17'd131071, 17'd131071, 17'd65535, 17'd65535);
        send_frame(16'h7fff, 16'h7fff);
        send_frame(16'h8000, 16'h8000);
        send_frame(16'h7fff, 16'h8000);
        send_frame(16'h0001, 16'hffff);
        send_frame(16'h0000, 16'h0000);
        send_frame(16'h8000, 16'h7fff);
        drain_block();

        // unity feedback, even split, dry muted, right line of length one
        apply_settings(17'd5, 17'd1, 17'd65536, 17'd32768, 17'd4096, 17'd0);
        send_frame(16'h7fff, 16'h0000);
        send_frame(16'h0000, 16'h8000);
        send_frame(16'h4000, 16'hc000);
        send_frame(16'hffff, 16'hffff);
        send_frame(16'h0001, 16'h0001);
        send_frame(16'h7fff, 16'h7fff);
        send_frame(16'h8000, 16'h8000);
        send_frame(16'h0000, 16'h0000);
        drain_block();

        // left line shrunk below its write position: it restarts at zero
        apply_settings(17'd2, 17'd1, 17'd45000, 17'd20000, 17'd8191, 17'd2048);
        send_frame(16'h3039, 16'hcfc7);
        send_frame(16'hb1e0, 16'h7530);
        send_frame(16'h7fff, 16'h8000);
        send_frame(16'hfffe, 16'h0002);
        drain_block();

        // --- random segments ---
        for (seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 0) begin
                apply_settings(17'd1, 17'd1, 17'd0, 17'd0, 17'd0, 17'd0);
            end else if (seg == SEGMENTS - 1) begin
                apply_settings(17'd65536, 17'd65536, 17'd65536, 17'd65536,
                               17'd65535, 17'd65535);
            end else begin
                apply_settings(pick_length(), pick_length(), pick_q16(), pick_q16(),
                               pick_gain(), pick_gain());
            end
            // idling pattern rotates: none, sender, receiver, both light
            case (seg % 4)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 76; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 76; end
                default: begin idle_pct = 6; stall_pct <= 6; end
            endcase
            for (k = 0; k < SEG_WORDS; k++) begin
                // receiver freezes while the sender keeps pushing
                if (seg == 4 && k == 30) hold_flip <= ~hold_flip;
                // sender waits for the pipe to empty mid-segment
                if (seg == 5 && k == 50) begin
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                    while (pending_words != 0) @(posedge aclk);
                end
                send_frame(pick_sample(), pick_sample());
            end
            drain_block();
        end

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
